// ----- rtl/core/tlac_pkg.sv -----
package tlac_pkg;

  localparam int unsigned KEY_W   = 10;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned PAGE_W  = 11;
  localparam int unsigned COST_W  = 11;
  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned DIV_CNT_W = $clog2(POS_W + 1);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ACCESS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_HERE,
    ST_PREV,
    ST_SWAP,
    ST_WAIT
  } tlac_state_e;

  typedef struct packed {
    logic              start;
    logic [POS_W-1:0]  dividend;
    logic [PAGE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [POS_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/transpose_list_access_cost.sv -----
// load: written to both tables at once when key and position are in range, no result
// access: a result strobe follows the transfer (none for a key out of range), busy until then; the 10-step
// bit-serial page divide paces the result, the table reads and swap writes run beside it
// results are shown for one cycle; the receiver cannot stall, next item may start then
// reset clears control, total cost and page size (to 1); the tables hold no reset value
module transpose_list_access_cost #(
  parameter int ENTRIES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode_i,
  input  logic [tlac_pkg::KEY_W-1:0]     key_i,
  input  logic [tlac_pkg::POS_W-1:0]     position_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tlac_pkg::PAGE_W-1:0]    cfg_data_i,
  output logic                           result_strobe_o,
  output logic [tlac_pkg::POS_W-1:0]     found_position_o,
  output logic [tlac_pkg::COST_W-1:0]    access_cost_o,
  output logic [tlac_pkg::TOTAL_W-1:0]   total_cost_o
);
  import tlac_pkg::*;

  // keys and positions are 10 bits, so no more than 1024 entries can be reached
  localparam int DEPTH = (ENTRIES < (1 << KEY_W)) ? ENTRIES : (1 << KEY_W);
  localparam int AW    = $clog2(DEPTH);

  logic [POS_W-1:0] order_mem [DEPTH];
  logic [POS_W-1:0] pidx_mem  [DEPTH];
  logic [POS_W-1:0] order_rdata_q;
  logic [POS_W-1:0] pidx_rdata_q;

  logic             order_re, pidx_re;
  logic [AW-1:0]    order_raddr, pidx_raddr;
  logic             order_we, pidx_we;
  logic [AW-1:0]    order_waddr, pidx_waddr;
  logic [POS_W-1:0] order_wdata, pidx_wdata;

  tlac_state_e         state_q, state_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    here_q, here_d;
  logic [PAGE_W-1:0]   page_size_q;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                strobe_q, strobe_d;
  logic [POS_W-1:0]    found_q, found_d;
  logic [COST_W-1:0]   cost_q, cost_d;

  logic                accept;
  logic                key_ok, pos_ok;
  logic [POS_W-1:0]    pos_rd;
  logic [POS_W-1:0]    pos_m1;
  logic [COST_W-1:0]   cost;
  logic [TOTAL_W:0]    sum;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tlac_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign key_ok = 32'(key_i) < ENTRIES;
  assign pos_ok = 32'(position_i) < ENTRIES;
  // a stored position beyond the table reads as the head
  assign pos_rd = (32'(pidx_rdata_q) >= ENTRIES) ? '0 : pidx_rdata_q;
  assign pos_m1 = pos_q - POS_W'(1);

  assign cost = COST_W'(div_rsp.quotient) + COST_W'(1);
  assign sum  = {1'b0, total_q} + (TOTAL_W + 1)'(cost);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    here_d   = here_q;
    total_d  = total_q;
    strobe_d = 1'b0;
    found_d  = found_q;
    cost_d   = cost_q;

    order_re    = 1'b0;
    order_raddr = pos_q[AW-1:0];
    pidx_re     = 1'b0;
    pidx_raddr  = key_i[AW-1:0];
    order_we    = 1'b0;
    order_waddr = position_i[AW-1:0];
    order_wdata = key_i;
    pidx_we     = 1'b0;
    pidx_waddr  = key_i[AW-1:0];
    pidx_wdata  = position_i;

    div_req.start    = 1'b0;
    div_req.dividend = pos_rd;
    div_req.divisor  = page_size_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_LOAD) begin
            order_we = key_ok && pos_ok;
            pidx_we  = key_ok && pos_ok;
          end else if (key_ok) begin
            pidx_re = 1'b1;
            state_d = ST_POS;
          end
        end
      end
      ST_POS: begin
        pos_d         = pos_rd;
        div_req.start = 1'b1;
        if (pos_rd != '0) begin
          order_re    = 1'b1;
          order_raddr = pos_rd[AW-1:0];
          state_d     = ST_HERE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_HERE: begin
        here_d      = order_rdata_q;
        order_re    = 1'b1;
        order_raddr = pos_m1[AW-1:0];
        state_d     = ST_PREV;
      end
      ST_PREV: begin
        // predecessor moves down one place
        order_we    = 1'b1;
        order_waddr = pos_q[AW-1:0];
        order_wdata = order_rdata_q;
        pidx_we     = 32'(order_rdata_q) < ENTRIES;
        pidx_waddr  = order_rdata_q[AW-1:0];
        pidx_wdata  = pos_q;
        state_d     = ST_SWAP;
      end
      ST_SWAP: begin
        // accessed key moves up; written last so it wins if both keys match
        order_we    = 1'b1;
        order_waddr = pos_m1[AW-1:0];
        order_wdata = here_q;
        pidx_we     = 32'(here_q) < ENTRIES;
        pidx_waddr  = here_q[AW-1:0];
        pidx_wdata  = pos_m1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (!div_rsp.busy) begin
          total_d  = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
          strobe_d = 1'b1;
          found_d  = pos_q;
          cost_d   = cost;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      strobe_q    <= 1'b0;
      page_size_q <= PAGE_W'(1);
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        page_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    here_q  <= here_d;
    found_q <= found_d;
    cost_q  <= cost_d;
  end

  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    if (order_re) begin
      order_rdata_q <= order_mem[order_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pidx_we) begin
      pidx_mem[pidx_waddr] <= pidx_wdata;
    end
    if (pidx_re) begin
      pidx_rdata_q <= pidx_mem[pidx_raddr];
    end
  end

  assign result_strobe_o  = strobe_q;
  assign found_position_o = found_q;
  assign access_cost_o    = cost_q;
  assign total_cost_o     = total_q;

endmodule

// ----- rtl/core/tlac_div.sv -----
module tlac_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlac_pkg::div_req_t req_i,
  output tlac_pkg::div_rsp_t rsp_o
);
  import tlac_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0]     dvd_q, dvd_d;
  logic [PAGE_W-1:0]    rem_q, rem_d;
  logic [PAGE_W-1:0]    dvs_q, dvs_d;
  logic [PAGE_W:0]      rem_sh;
  logic [PAGE_W:0]      diff;
  logic                 fits;

  // restoring division, one quotient bit per cycle shifted into the dividend register
  assign rem_sh = {rem_q, dvd_q[POS_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(POS_W);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      // a page size of zero acts as one
      dvs_d  = (req_i.divisor == '0) ? PAGE_W'(1) : req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[POS_W-2:0], fits};
      rem_d = fits ? diff[PAGE_W-1:0] : rem_sh[PAGE_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import tlac_pkg::*;

  localparam int ENTRIES    = 1024;
  localparam int SETTLE     = 16;    // extra wait after the results have drained
  localparam int STALL_MAX  = 1000;  // cycles with no transfer before giving up
  localparam int PHASE_LEN  = 195;
  localparam int N_PHASES   = 7;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [POS_W-1:0]   found;
    logic [COST_W-1:0]  cost;
    logic [TOTAL_W-1:0] total;
  } access_rec_t;

  typedef struct packed {
    bit                is_page;
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  posn;
    logic [PAGE_W-1:0] page;
    bit                typed;
    access_rec_t       want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                mode_i;
  logic [KEY_W-1:0]    key_i;
  logic [POS_W-1:0]    position_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [PAGE_W-1:0]   cfg_data_i;
  logic                result_strobe_o;
  logic [POS_W-1:0]    found_position_o;
  logic [COST_W-1:0]   access_cost_o;
  logic [TOTAL_W-1:0]  total_cost_o;

  // predictor state
  logic [KEY_W-1:0]    order_tbl [ENTRIES];
  logic [POS_W-1:0]    pos_idx [ENTRIES];
  bit                  pos_loaded [ENTRIES];
  bit                  key_loaded [ENTRIES];
  logic [KEY_W-1:0]    loaded_keys [$];
  logic [POS_W-1:0]    filled_pos [$];
  logic [TOTAL_W-1:0]  cost_sum;
  logic [PAGE_W-1:0]   page_size;

  access_rec_t         pending_costs [$];
  access_rec_t         head_rec;
  stim_row_t           dir_rows [$];

  int mismatches;
  int results_checked;
  int n_loads;
  int n_access;
  int idle_cycles;

  transpose_list_access_cost #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .key_i           (key_i),
    .position_i      (position_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .found_position_o(found_position_o),
    .access_cost_o   (access_cost_o),
    .total_cost_o    (total_cost_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // applies one item to the list model, returns the access record if any
  task automatic advance_list(input logic m, input logic [KEY_W-1:0] k,
                              input logic [POS_W-1:0] p, output bit produced,
                              output access_rec_t rec);
    logic [POS_W-1:0]   at;
    logic [KEY_W-1:0]   here;
    logic [KEY_W-1:0]   prev;
    logic [PAGE_W-1:0]  div;
    logic [COST_W-1:0]  quot;
    logic [TOTAL_W:0]   sum;
    produced = 1'b0;
    rec = '0;
    if (m == MODE_LOAD) begin
      order_tbl[p] = k;
      pos_idx[k] = p;
      if (!pos_loaded[p]) begin
        pos_loaded[p] = 1'b1;
        filled_pos = {filled_pos, p};
      end
      if (!key_loaded[k]) begin
        key_loaded[k] = 1'b1;
        loaded_keys = {loaded_keys, k};
      end
    end else begin
      at = pos_idx[k];
      div = (page_size == '0) ? 11'd1 : page_size;
      quot = {1'b0, at} / div;
      rec.found = at;
      rec.cost = quot + 11'd1;
      sum = {1'b0, cost_sum} + {30'd0, rec.cost};
      cost_sum = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      rec.total = cost_sum;
      // transpose: swap with the predecessor slot, whatever keys sit there
      if (at != '0) begin
        here = order_tbl[at];
        prev = order_tbl[at - 1'b1];
        order_tbl[at] = prev;
        order_tbl[at - 1'b1] = here;
        pos_idx[prev] = at;
        pos_idx[here] = at - 1'b1;
      end
      produced = 1'b1;
    end
  endtask

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic m, input logic [KEY_W-1:0] k,
                           input logic [POS_W-1:0] p, input int gap,
                           input bit typed, input access_rec_t want);
    bit          produced;
    access_rec_t rec;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    mode_i     <= m;
    key_i      <= k;
    position_i <= p;
    do @(posedge clk_i); while (busy);
    advance_list(m, k, p, produced, rec);
    if (produced) begin
      pending_costs = {pending_costs, (typed ? want : rec)};
      n_access++;
    end else begin
      n_loads++;
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_costs.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_page(input logic [PAGE_W-1:0] value);
    pause_until_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    page_size = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input stim_row_t r);
    dir_rows = {dir_rows, r};
  endtask

  function automatic stim_row_t row_load(input int k, input int p);
    stim_row_t r;
    r = '0;
    r.mode = MODE_LOAD;
    r.key = k[KEY_W-1:0];
    r.posn = p[POS_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t row_access(input int k);
    stim_row_t r;
    r = '0;
    r.mode = MODE_ACCESS;
    r.key = k[KEY_W-1:0];
    r.posn = ~k[POS_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t row_checked(input int k, input int f, input int c,
                                            input longint t);
    stim_row_t r;
    r = row_access(k);
    r.typed = 1'b1;
    r.want.found = f[POS_W-1:0];
    r.want.cost = c[COST_W-1:0];
    r.want.total = t[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t row_page(input int v);
    stim_row_t r;
    r = '0;
    r.is_page = 1'b1;
    r.page = v[PAGE_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (pending_costs.size() == 0) begin
        flag_mismatch("unexpected result, total_cost", '0, total_cost_o);
      end else begin
        head_rec = pending_costs.pop_front();
        if (found_position_o !== head_rec.found)
          flag_mismatch("found_position", TOTAL_W'(head_rec.found),
                        TOTAL_W'(found_position_o));
        if (access_cost_o !== head_rec.cost)
          flag_mismatch("access_cost", TOTAL_W'(head_rec.cost), TOTAL_W'(access_cost_o));
        if (total_cost_o !== head_rec.total)
          flag_mismatch("total_cost", head_rec.total, total_cost_o);
        results_checked++;
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 STALL_MAX, pending_costs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [PAGE_W-1:0] phase_pages [N_PHASES];
    logic [KEY_W-1:0]  k;
    logic [POS_W-1:0]  p;
    logic [31:0]       rnd;
    int                seg_len;
    int                base;
    int                r;
    bit                hit;
    bit                steady;

    rst_ni      = 1'b0;
    start       = 1'b0;
    mode_i      = MODE_LOAD;
    key_i       = '0;
    position_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    mismatches = 0;
    results_checked = 0;
    n_loads = 0;
    n_access = 0;
    cost_sum = '0;
    page_size = 11'd1;
    for (int i = 0; i < ENTRIES; i++) begin
      order_tbl[i] = '0;
      pos_idx[i] = '0;
      pos_loaded[i] = 1'b0;
      key_loaded[i] = 1'b0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: a small list, head and tail of the position range, stale index
    // entries, zero and extreme page sizes
    add_row(row_load(1023, 0));
    add_row(row_load(0, 1));
    add_row(row_load(5, 2));
    add_row(row_checked(1023, 0, 1, 1));
    add_row(row_access(5));
    add_row(row_access(5));
    add_row(row_access(5));
    add_row(row_load(3, 1022));
    add_row(row_load(1023, 1023));
    add_row(row_checked(1023, 1023, 1024, 1031));
    add_row(row_checked(3, 1023, 1024, 2055));
    add_row(row_access(0));
    add_row(row_access(1023));
    add_row(row_page(0));
    add_row(row_load(7, 1021));
    add_row(row_access(3));
    add_row(row_page(1024));
    add_row(row_access(7));
    add_row(row_load(512, 1020));
    add_row(row_access(7));
    add_row(row_page(2047));
    add_row(row_access(512));
    add_row(row_load(682, 681));
    add_row(row_load(341, 682));
    add_row(row_page(3));
    add_row(row_access(341));
    add_row(row_page(1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_page)
        write_page(dir_rows[i].page);
      else
        send_item(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].posn, pick_gap(1'b0),
                  dir_rows[i].typed, dir_rows[i].want);
    end

    // seed three list segments: the front, the tail and one in the middle
    seg_len = $urandom_range(24, 64);
    for (int i = 0; i < seg_len; i++) begin
      rnd = $urandom;
      send_item(MODE_LOAD, rnd[KEY_W-1:0], i[POS_W-1:0], pick_gap(1'b0), 1'b0, '0);
    end
    base = $urandom_range(64, 900);
    for (int i = 0; i < 16; i++) begin
      rnd = $urandom;
      p = POS_W'(base + i);
      send_item(MODE_LOAD, rnd[KEY_W-1:0], p, pick_gap(1'b0), 1'b0, '0);
      p = POS_W'(ENTRIES - 16 + i);
      send_item(MODE_LOAD, rnd[KEY_W+9:10], p, pick_gap(1'b0), 1'b0, '0);
    end

    phase_pages[0] = 11'd1024;
    phase_pages[1] = 11'd0;
    phase_pages[2] = 11'd2047;
    phase_pages[3] = PAGE_W'($urandom_range(2, 64));
    phase_pages[4] = PAGE_W'($urandom_range(65, 1023));
    phase_pages[5] = 11'd1;
    phase_pages[6] = PAGE_W'($urandom_range(1025, 2046));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_page(phase_pages[ph]);
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        r = $urandom_range(0, 99);
        rnd = $urandom;
        hit = 1'b0;
        // only access keys whose slot and predecessor slot were written
        if (r < 80) begin
          for (int t = 0; t < 16 && !hit; t++) begin
            k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
            hit = (pos_idx[k] == '0) || pos_loaded[pos_idx[k] - 1'b1];
          end
        end
        if (hit) begin
          send_item(MODE_ACCESS, k, rnd[POS_W-1:0], pick_gap(steady), 1'b0, '0);
        end else if (r < 92) begin
          // extend or overwrite next to an existing entry
          p = filled_pos[$urandom_range(0, filled_pos.size() - 1)] + rnd[10];
          send_item(MODE_LOAD, rnd[KEY_W-1:0], p, pick_gap(steady), 1'b0, '0);
        end else begin
          send_item(MODE_LOAD, rnd[KEY_W-1:0], rnd[KEY_W+POS_W-1:KEY_W],
                    pick_gap(steady), 1'b0, '0);
        end
        if ($urandom_range(0, 63) == 0)
          pause_until_drained();
      end
    end

    pause_until_drained();
    repeat (2 * SETTLE) @(posedge clk_i);

    $display("ran %0d loads and %0d accesses, %0d results compared, %0d mismatches",
             n_loads, n_access, results_checked, mismatches);
    $display("page sizes covered: reset 1, 0, 3, 1024, 2047 and %0d random ones",
             N_PHASES - 4);
    if (mismatches == 0 && pending_costs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tlac_pkg.sv
rtl/core/tlac_div.sv
rtl/core/transpose_list_access_cost.sv
tb/tb_top.sv
